// File: hdl/lsra_pkg.sv
// Shared types, constants and a helper function for the linear-scan register assigner.
`default_nettype none
package lsra_pkg;

    localparam int ACTIVE_DEPTH = 64;
    localparam int ADDR_W       = $clog2(ACTIVE_DEPTH);
    localparam int CNT_W        = $clog2(ACTIVE_DEPTH + 1);
    localparam int SLOT_W       = 17;

    // Register classes.
    localparam logic [1:0] CLS_NONE = 2'd0;
    localparam logic [1:0] CLS_GPR  = 2'd1;
    localparam logic [1:0] CLS_XMM  = 2'd2;
    localparam logic [1:0] CLS_RSVD = 2'd3;

    // Allocation kinds.
    localparam logic [1:0] KIND_REG   = 2'd0;
    localparam logic [1:0] KIND_SPILL = 2'd1;
    localparam logic [1:0] KIND_PAIR  = 2'd2;

    // Configuration register indexes.
    localparam logic [3:0] CFG_GPR_COUNT = 4'd0;
    localparam logic [3:0] CFG_XMM_COUNT = 4'd1;

    // Datapath operations issued by the controller.
    localparam logic [3:0] OP_NONE      = 4'd0;
    localparam logic [3:0] OP_LOAD      = 4'd1;
    localparam logic [3:0] OP_EXP_RD    = 4'd2;
    localparam logic [3:0] OP_EXP_CHK   = 4'd3;
    localparam logic [3:0] OP_MV_RD     = 4'd4;
    localparam logic [3:0] OP_MV_WR     = 4'd5;
    localparam logic [3:0] OP_SCAN_INIT = 4'd6;
    localparam logic [3:0] OP_SCAN      = 4'd7;
    localparam logic [3:0] OP_DECIDE    = 4'd8;

    typedef struct packed {
        logic [15:0] id;
        logic [15:0] iend;
        logic [4:0]  rnum;
        logic [1:0]  cls;
    } entry_t;

    typedef struct packed {
        logic [3:0] op;
    } cmd_t;

    typedef struct packed {
        logic idx_lt_cnt;
        logic expired;
        logic pend;
        logic out_free;
    } status_t;

    // Mask of the first n registers, saturating at all 32.
    function automatic logic [31:0] count_mask(input logic [5:0] n);
        logic [31:0] m;
        if (n >= 6'd32)
            m = 32'hFFFF_FFFF;
        else
            m = (32'd1 << n[4:0]) - 32'd1;
        return m;
    endfunction

endpackage
`default_nettype wire

// File: hdl/lsra_ctrl.sv
// Controller state machine that sequences expiry, scan and decision for each beat.
`default_nettype none
module lsra_ctrl
    import lsra_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_stall,
    input  wire status_t sts,
    output cmd_t         cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXP_RD = 3'd1;
    localparam logic [2:0] S_EXP_CK = 3'd2;
    localparam logic [2:0] S_MV_RD  = 3'd3;
    localparam logic [2:0] S_MV_WR  = 3'd4;
    localparam logic [2:0] S_SCAN   = 3'd5;
    localparam logic [2:0] S_DECIDE = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_EXP_RD;
                end
            end
            S_EXP_RD:
            begin
                if (sts.idx_lt_cnt)
                begin
                    cmd.op     = OP_EXP_RD;
                    state_next = S_EXP_CK;
                end
                else
                begin
                    cmd.op     = OP_SCAN_INIT;
                    state_next = S_SCAN;
                end
            end
            S_EXP_CK:
            begin
                cmd.op     = OP_EXP_CHK;
                state_next = sts.expired ? S_MV_RD : S_EXP_RD;
            end
            S_MV_RD:
            begin
                cmd.op     = OP_MV_RD;
                state_next = S_MV_WR;
            end
            S_MV_WR:
            begin
                cmd.op     = OP_MV_WR;
                state_next = S_EXP_RD;
            end
            S_SCAN:
            begin
                cmd.op = OP_SCAN;
                if (!sts.idx_lt_cnt && !sts.pend)
                    state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (sts.out_free)
                begin
                    cmd.op     = OP_DECIDE;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule
`default_nettype wire

// File: hdl/lsra_dp.sv
// Datapath: active-list memory, scan accumulators, counters and the result register.
`default_nettype none
module lsra_dp
    import lsra_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire cmd_t          cmd,
    output status_t            sts,
    input  wire logic          cfg_we,
    input  wire logic [3:0]    cfg_index,
    input  wire logic [5:0]    cfg_data,
    input  wire logic [15:0]   reg_id,
    input  wire logic [15:0]   interval_start,
    input  wire logic [15:0]   interval_end,
    input  wire logic [1:0]    reg_class,
    input  wire logic          is_paired,
    input  wire logic [31:0]   forbidden_mask,
    input  wire logic          new_function,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic [1:0]         alloc_kind,
    output logic [4:0]         reg_num,
    output logic [SLOT_W-1:0]  slot_first,
    output logic [SLOT_W-1:0]  slot_second,
    output logic               victim_valid,
    output logic [15:0]        victim_id,
    output logic [SLOT_W-1:0]  victim_slot,
    output logic [31:0]        gpr_given_mask,
    output logic [31:0]        xmm_given_mask,
    output logic [SLOT_W-1:0]  slot_total
);

    entry_t mem [ACTIVE_DEPTH];
    entry_t rd_data_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic              we;
    logic [ADDR_W-1:0] wa;
    entry_t            wd;

    // Item registers.
    logic [15:0] id_reg, id_next;
    logic [15:0] start_reg, start_next;
    logic [15:0] end_reg, end_next;
    logic [1:0]  cls_reg, cls_next;
    logic        paired_reg, paired_next;
    logic [31:0] forbid_reg, forbid_next;

    // Function state and configuration.
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [SLOT_W-1:0] spill_reg, spill_next;
    logic [31:0]       gused_reg, gused_next;
    logic [31:0]       xused_reg, xused_next;
    logic [5:0]        gcnt_reg, gcnt_next;
    logic [5:0]        xcnt_reg, xcnt_next;

    // Scan accumulators.
    logic              pend_reg, pend_next;
    logic [ADDR_W-1:0] pidx_reg, pidx_next;
    logic [31:0]       avail_reg, avail_next;
    logic [15:0]       vend_reg, vend_next;
    logic [ADDR_W-1:0] vix_reg, vix_next;
    logic [4:0]        vreg_reg, vreg_next;
    logic [15:0]       vid_reg, vid_next;
    logic              found_reg, found_next;

    // Result register.
    logic              ov_reg, ov_next;
    logic [1:0]        okind_reg, okind_next;
    logic [4:0]        oreg_reg, oreg_next;
    logic [SLOT_W-1:0] os1_reg, os1_next;
    logic [SLOT_W-1:0] os2_reg, os2_next;
    logic              ovv_reg, ovv_next;
    logic [15:0]       ovid_reg, ovid_next;
    logic [SLOT_W-1:0] ovs_reg, ovs_next;
    logic [31:0]       ogm_reg, ogm_next;
    logic [31:0]       oxm_reg, oxm_next;
    logic [SLOT_W-1:0] osc_reg, osc_next;

    logic [31:0] cmask;
    logic [31:0] avail_fin;
    logic [4:0]  pick;

    assign sts.idx_lt_cnt = (idx_reg < cnt_reg);
    assign sts.expired    = (rd_data_reg.iend < start_reg);
    assign sts.pend       = pend_reg;
    assign sts.out_free   = !ov_reg || !out_stall;

    assign cmask = (cls_reg == CLS_GPR) ? count_mask(gcnt_reg) :
                   (cls_reg == CLS_XMM) ? count_mask(xcnt_reg) : 32'd0;

    assign avail_fin = (cls_reg == CLS_NONE || cnt_reg >= CNT_W'(ACTIVE_DEPTH)) ?
                       32'd0 : avail_reg;

    always_comb
    begin
        pick = 5'd0;
        for (int i = 31; i >= 0; i--)
        begin
            if (avail_fin[i])
                pick = 5'(i);
        end
    end

    always_comb
    begin
        id_next     = id_reg;
        start_next  = start_reg;
        end_next    = end_reg;
        cls_next    = cls_reg;
        paired_next = paired_reg;
        forbid_next = forbid_reg;
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        spill_next  = spill_reg;
        gused_next  = gused_reg;
        xused_next  = xused_reg;
        gcnt_next   = gcnt_reg;
        xcnt_next   = xcnt_reg;
        pend_next   = pend_reg;
        pidx_next   = pidx_reg;
        avail_next  = avail_reg;
        vend_next   = vend_reg;
        vix_next    = vix_reg;
        vreg_next   = vreg_reg;
        vid_next    = vid_reg;
        found_next  = found_reg;
        ov_next     = ov_reg && out_stall;
        okind_next  = okind_reg;
        oreg_next   = oreg_reg;
        os1_next    = os1_reg;
        os2_next    = os2_reg;
        ovv_next    = ovv_reg;
        ovid_next   = ovid_reg;
        ovs_next    = ovs_reg;
        ogm_next    = ogm_reg;
        oxm_next    = oxm_reg;
        osc_next    = osc_reg;
        rd_addr     = idx_reg[ADDR_W-1:0];
        we          = 1'b0;
        wa          = idx_reg[ADDR_W-1:0];
        wd          = rd_data_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_GPR_COUNT: gcnt_next = cfg_data;
                CFG_XMM_COUNT: xcnt_next = cfg_data;
                default: ;
            endcase
        end

        case (cmd.op)
            OP_LOAD:
            begin
                id_next     = reg_id;
                start_next  = interval_start;
                end_next    = interval_end;
                cls_next    = (reg_class == CLS_RSVD) ? CLS_NONE : reg_class;
                paired_next = is_paired;
                forbid_next = forbidden_mask;
                idx_next    = '0;
                if (new_function)
                begin
                    cnt_next   = '0;
                    spill_next = '0;
                    gused_next = '0;
                    xused_next = '0;
                end
            end
            OP_EXP_RD:
            begin
                rd_addr = idx_reg[ADDR_W-1:0];
            end
            OP_EXP_CHK:
            begin
                if (rd_data_reg.iend < start_reg)
                    cnt_next = cnt_reg - CNT_W'(1);
                else
                    idx_next = idx_reg + CNT_W'(1);
            end
            OP_MV_RD:
            begin
                rd_addr = cnt_reg[ADDR_W-1:0];
            end
            OP_MV_WR:
            begin
                we = 1'b1;
                wa = idx_reg[ADDR_W-1:0];
                wd = rd_data_reg;
            end
            OP_SCAN_INIT:
            begin
                idx_next   = '0;
                pend_next  = 1'b0;
                avail_next = cmask & ~forbid_reg;
                vend_next  = '0;
                found_next = 1'b0;
            end
            OP_SCAN:
            begin
                rd_addr   = idx_reg[ADDR_W-1:0];
                pend_next = (idx_reg < cnt_reg);
                pidx_next = idx_reg[ADDR_W-1:0];
                if (idx_reg < cnt_reg)
                    idx_next = idx_reg + CNT_W'(1);
                if (pend_reg && rd_data_reg.cls == cls_reg)
                begin
                    avail_next = avail_reg & ~(32'd1 << rd_data_reg.rnum);
                    if (rd_data_reg.iend > vend_reg)
                    begin
                        vend_next  = rd_data_reg.iend;
                        vix_next   = pidx_reg;
                        vreg_next  = rd_data_reg.rnum;
                        vid_next   = rd_data_reg.id;
                        found_next = 1'b1;
                    end
                end
            end
            OP_DECIDE:
            begin
                ov_next    = 1'b1;
                okind_next = KIND_REG;
                oreg_next  = '0;
                os1_next   = '0;
                os2_next   = '0;
                ovv_next   = 1'b0;
                ovid_next  = '0;
                ovs_next   = '0;
                if (paired_reg)
                begin
                    okind_next = KIND_PAIR;
                    os1_next   = spill_reg;
                    os2_next   = spill_reg + SLOT_W'(1);
                    spill_next = spill_reg + SLOT_W'(2);
                end
                else if (avail_fin != 32'd0)
                begin
                    oreg_next = pick;
                    if (cls_reg == CLS_GPR)
                        gused_next = gused_reg | (32'd1 << pick);
                    else
                        xused_next = xused_reg | (32'd1 << pick);
                    we       = 1'b1;
                    wa       = cnt_reg[ADDR_W-1:0];
                    wd       = '{id: id_reg, iend: end_reg, rnum: pick, cls: cls_reg};
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                else if (cls_reg != CLS_NONE && found_reg && vend_reg > end_reg)
                begin
                    oreg_next  = vreg_reg;
                    ovv_next   = 1'b1;
                    ovid_next  = vid_reg;
                    ovs_next   = spill_reg;
                    spill_next = spill_reg + SLOT_W'(1);
                    we         = 1'b1;
                    wa         = vix_reg;
                    wd         = '{id: id_reg, iend: end_reg, rnum: vreg_reg, cls: cls_reg};
                end
                else
                begin
                    okind_next = KIND_SPILL;
                    os1_next   = spill_reg;
                    spill_next = spill_reg + SLOT_W'(1);
                end
                // The function totals are frozen into the result so that a later
                // new-function beat cannot disturb a result that is still waiting.
                ogm_next = gused_next;
                oxm_next = xused_next;
                osc_next = spill_next;
            end
            default: ;
        endcase
    end

    // Active-list memory with a registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            idx_reg   <= '0;
            spill_reg <= '0;
            gused_reg <= '0;
            xused_reg <= '0;
            gcnt_reg  <= 6'd11;
            xcnt_reg  <= 6'd8;
            pend_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            spill_reg <= spill_next;
            gused_reg <= gused_next;
            xused_reg <= xused_next;
            gcnt_reg  <= gcnt_next;
            xcnt_reg  <= xcnt_next;
            pend_reg  <= pend_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg     <= id_next;
        start_reg  <= start_next;
        end_reg    <= end_next;
        cls_reg    <= cls_next;
        paired_reg <= paired_next;
        forbid_reg <= forbid_next;
        pidx_reg   <= pidx_next;
        avail_reg  <= avail_next;
        vend_reg   <= vend_next;
        vix_reg    <= vix_next;
        vreg_reg   <= vreg_next;
        vid_reg    <= vid_next;
        found_reg  <= found_next;
        okind_reg  <= okind_next;
        oreg_reg   <= oreg_next;
        os1_reg    <= os1_next;
        os2_reg    <= os2_next;
        ovv_reg    <= ovv_next;
        ovid_reg   <= ovid_next;
        ovs_reg    <= ovs_next;
        ogm_reg    <= ogm_next;
        oxm_reg    <= oxm_next;
        osc_reg    <= osc_next;
    end

    assign out_valid      = ov_reg;
    assign alloc_kind     = okind_reg;
    assign reg_num        = oreg_reg;
    assign slot_first     = os1_reg;
    assign slot_second    = os2_reg;
    assign victim_valid   = ovv_reg;
    assign victim_id      = ovid_reg;
    assign victim_slot    = ovs_reg;
    assign gpr_given_mask = ogm_reg;
    assign xmm_given_mask = oxm_reg;
    assign slot_total     = osc_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(ACTIVE_DEPTH))
        else $error("active count exceeds the list depth");

    a_chk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_EXP_CHK |-> idx_reg < cnt_reg)
        else $error("expiry check outside the active entries");

    a_decide_loads: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_DECIDE |=> ov_reg)
        else $error("decision did not fill the result register");

    a_decide_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_DECIDE |-> (!ov_reg || !out_stall))
        else $error("decision overwrote a result still waiting");

endmodule
`default_nettype wire

// File: hdl/linear_scan_register_assign.sv
// Top level of the linear-scan register assigner: controller plus datapath.
// Each beat is loaded, then each active entry is checked for expiry (an expired entry
// is replaced by the last one), then the active list is scanned and the decision made;
// the decision waits while the output register holds a result that is stalled.
// Throughput: one beat at a time; the next beat is taken once the decision is made,
// so a result may wait in the output register while the next beat is worked on.
// Reset clears the active count, spill counter, used masks and the handshakes and
// restores the class counts to 11 and 8; the active-list memory is not cleared.
`default_nettype none
module linear_scan_register_assign
    import lsra_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [3:0]        cfg_index,
    input  wire logic [5:0]        cfg_data,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [15:0]       reg_id,
    input  wire logic [15:0]       interval_start,
    input  wire logic [15:0]       interval_end,
    input  wire logic [1:0]        reg_class,
    input  wire logic              is_paired,
    input  wire logic [31:0]       forbidden_mask,
    input  wire logic              new_function,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [1:0]             alloc_kind,
    output logic [4:0]             reg_num,
    output logic [SLOT_W-1:0]      slot_first,
    output logic [SLOT_W-1:0]      slot_second,
    output logic                   victim_valid,
    output logic [15:0]            victim_id,
    output logic [SLOT_W-1:0]      victim_slot,
    output logic [31:0]            gpr_given_mask,
    output logic [31:0]            xmm_given_mask,
    output logic [SLOT_W-1:0]      slot_total
);

    cmd_t    cmd;
    status_t sts;

    // Configuration writes are always taken; the user must send them only while idle, the block does not enforce it.
    assign cfg_ready = 1'b1;

    // The controller walks each beat through expiry, scan and decision.
    lsra_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath holds the active list, the function state and the result.
    lsra_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .cfg_we         (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .reg_id         (reg_id),
        .interval_start (interval_start),
        .interval_end   (interval_end),
        .reg_class      (reg_class),
        .is_paired      (is_paired),
        .forbidden_mask (forbidden_mask),
        .new_function   (new_function),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .alloc_kind     (alloc_kind),
        .reg_num        (reg_num),
        .slot_first     (slot_first),
        .slot_second    (slot_second),
        .victim_valid   (victim_valid),
        .victim_id      (victim_id),
        .victim_slot    (victim_slot),
        .gpr_given_mask (gpr_given_mask),
        .xmm_given_mask (xmm_given_mask),
        .slot_total     (slot_total)
    );

endmodule
`default_nettype wire

// File: sim/tb_top.sv
// Self-checking testbench for the linear-scan register assigner.
`default_nettype none
module tb_top
    import lsra_pkg::*;
;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [3:0] cfg_index;
    logic [5:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic [15:0] reg_id;
    logic [15:0] interval_start;
    logic [15:0] interval_end;
    logic [1:0] reg_class;
    logic is_paired;
    logic [31:0] forbidden_mask;
    logic new_function;
    logic out_valid;
    logic out_stall;
    logic [1:0] alloc_kind;
    logic [4:0] reg_num;
    logic [SLOT_W-1:0] slot_first;
    logic [SLOT_W-1:0] slot_second;
    logic victim_valid;
    logic [15:0] victim_id;
    logic [SLOT_W-1:0] victim_slot;
    logic [31:0] gpr_given_mask;
    logic [31:0] xmm_given_mask;
    logic [SLOT_W-1:0] slot_total;

    linear_scan_register_assign u_top (.*);

    // One interval beat as the sender presents it.
    typedef struct packed {
        logic [15:0] id;
        logic [15:0] istart;
        logic [15:0] iend;
        logic [1:0]  cls;
        logic        paired;
        logic [31:0] forbid;
        logic        newfn;
    } interval_t;

    // One allocation beat as the block returns it.
    typedef struct packed {
        logic [1:0]        kind;
        logic [4:0]        rnum;
        logic [SLOT_W-1:0] slot1;
        logic [SLOT_W-1:0] slot2;
        logic              vvalid;
        logic [15:0]       vid;
        logic [SLOT_W-1:0] vslot;
        logic [31:0]       gmask;
        logic [31:0]       xmask;
        logic [SLOT_W-1:0] scount;
    } alloc_t;

    // Directed row: the interval, and optionally a hand-written expectation.
    typedef struct {
        interval_t  item;
        bit         has_golden;
        alloc_t     golden;
    } row_t;

    // Predictor state, a private copy of what the block keeps.
    entry_t            live_tbl [ACTIVE_DEPTH];
    int                live_cnt;
    logic [SLOT_W-1:0] slot_next;
    logic [31:0]       gpr_taken;
    logic [31:0]       xmm_taken;
    logic [5:0]        n_gpr;
    logic [5:0]        n_xmm;

    alloc_t pending_allocs [$];
    int     fail_cnt;
    int     in_idle_pct;
    int     out_idle_pct;
    row_t   dir_rows [$];

    function automatic logic [31:0] regs_of(logic [5:0] n);
        logic [31:0] m;
        if (n >= 6'd32)
            m = 32'hFFFF_FFFF;
        else
            m = (32'd1 << n) - 32'd1;
        return m;
    endfunction

    function automatic logic [SLOT_W-1:0] grab_slot();
        logic [SLOT_W-1:0] s;
        s = slot_next;
        slot_next = slot_next + 1'b1;
        return s;
    endfunction

    // Works out the allocation for one interval and updates the private state.
    function automatic alloc_t assign_interval(interval_t it);
        alloc_t     r;
        logic [1:0] c;
        logic [31:0] avail;
        logic [31:0] cmask;
        int         i;
        int         vix;
        logic [15:0] vend;
        r = '0;
        c = (it.cls == CLS_RSVD) ? CLS_NONE : it.cls;
        if (it.newfn)
        begin
            live_cnt = 0;
            slot_next = '0;
            gpr_taken = '0;
            xmm_taken = '0;
        end
        i = 0;
        while (i < live_cnt)
        begin
            if (live_tbl[i].iend < it.istart)
            begin
                live_cnt--;
                live_tbl[i] = live_tbl[live_cnt];
            end
            else
                i++;
        end
        cmask = (c == CLS_GPR) ? regs_of(n_gpr) : (c == CLS_XMM) ? regs_of(n_xmm) : '0;
        avail = cmask & ~it.forbid;
        for (i = 0; i < live_cnt; i++)
            if (live_tbl[i].cls == c)
                avail[live_tbl[i].rnum] = 1'b0;
        if (it.paired)
        begin
            r.kind = KIND_PAIR;
            r.slot1 = grab_slot();
            r.slot2 = grab_slot();
        end
        else
        begin
            if (c == CLS_NONE || live_cnt >= ACTIVE_DEPTH)
                avail = '0;
            if (avail != '0)
            begin
                i = 0;
                while (!avail[i])
                    i++;
                r.kind = KIND_REG;
                r.rnum = i[4:0];
                if (c == CLS_GPR)
                    gpr_taken[i] = 1'b1;
                else
                    xmm_taken[i] = 1'b1;
                live_tbl[live_cnt] = '{id: it.id, iend: it.iend, rnum: i[4:0], cls: c};
                live_cnt++;
            end
            else
            begin
                vix = live_cnt;
                vend = '0;
                for (i = 0; i < live_cnt; i++)
                    if (live_tbl[i].cls == c && live_tbl[i].iend > vend)
                    begin
                        vend = live_tbl[i].iend;
                        vix = i;
                    end
                if (c != CLS_NONE && vix < live_cnt && vend > it.iend)
                begin
                    r.kind = KIND_REG;
                    r.rnum = live_tbl[vix].rnum;
                    r.vvalid = 1'b1;
                    r.vid = live_tbl[vix].id;
                    r.vslot = grab_slot();
                    live_tbl[vix].id = it.id;
                    live_tbl[vix].iend = it.iend;
                    live_tbl[vix].cls = c;
                end
                else
                begin
                    r.kind = KIND_SPILL;
                    r.slot1 = grab_slot();
                end
            end
        end
        r.gmask = gpr_taken;
        r.xmask = xmm_taken;
        r.scount = slot_next;
        return r;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Safety net well above the slowest legal run, stretched by sender and receiver stalls.
    initial
    begin
        #60000000;
        $display("Some tests failed");
        $finish;
    end

    // Result checker: every accepted beat is matched against the oldest prediction.
    always @(posedge clk)
    begin
        alloc_t got;
        alloc_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{alloc_kind, reg_num, slot_first, slot_second, victim_valid,
                    victim_id, victim_slot, gpr_given_mask, xmm_given_mask, slot_total};
            if (pending_allocs.size() == 0)
            begin
                $display("%0t: unexpected result beat %h", $time, got);
                fail_cnt++;
            end
            else
            begin
                want = pending_allocs.pop_front();
                if (got.kind !== want.kind)
                    $display("%0t: alloc_kind exp %0d got %0d", $time, want.kind, got.kind);
                if (got.rnum !== want.rnum)
                    $display("%0t: reg_num exp %0d got %0d", $time, want.rnum, got.rnum);
                if (got.slot1 !== want.slot1)
                    $display("%0t: slot_first exp %0d got %0d", $time, want.slot1, got.slot1);
                if (got.slot2 !== want.slot2)
                    $display("%0t: slot_second exp %0d got %0d", $time, want.slot2,
                             got.slot2);
                if (got.vvalid !== want.vvalid)
                    $display("%0t: victim_valid exp %0d got %0d", $time, want.vvalid,
                             got.vvalid);
                if (got.vid !== want.vid)
                    $display("%0t: victim_id exp %0d got %0d", $time, want.vid, got.vid);
                if (got.vslot !== want.vslot)
                    $display("%0t: victim_slot exp %0d got %0d", $time, want.vslot, got.vslot);
                if (got.gmask !== want.gmask)
                    $display("%0t: gpr_given_mask exp %h got %h", $time, want.gmask,
                             got.gmask);
                if (got.xmask !== want.xmask)
                    $display("%0t: xmm_given_mask exp %h got %h", $time, want.xmask,
                             got.xmask);
                if (got.scount !== want.scount)
                    $display("%0t: slot_total exp %0d got %0d", $time, want.scount,
                             got.scount);
                if (got !== want)
                    fail_cnt++;
            end
        end
    end

    // The receiver stalls at the current rate, changing only on the falling edge.
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < out_idle_pct);
    end

    // Drops the input valid and waits until every predicted result has come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_allocs.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_cfg(logic [3:0] idx, logic [5:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_GPR_COUNT)
            n_gpr = val;
        else if (idx == CFG_XMM_COUNT)
            n_xmm = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Presents one interval beat and records its predicted allocation on acceptance.
    // Valid stays high after acceptance until the next beat or a drain takes it down;
    // the block raises its stall as soon as it takes a beat, so nothing is taken twice.
    task automatic send_interval(interval_t it, bit has_golden, alloc_t golden);
        alloc_t p;
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        {reg_id, interval_start, interval_end, reg_class, is_paired, forbidden_mask,
         new_function} <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        p = assign_interval(it);
        if (has_golden && p !== golden)
        begin
            $display("%0t: predictor disagrees with table, exp %h got %h", $time, golden, p);
            fail_cnt++;
        end
        pending_allocs.push_back(p);
        @(negedge clk);
    endtask

    function automatic interval_t mk(logic [15:0] id, logic [15:0] s, logic [15:0] e,
                                     logic [1:0] c, logic pr, logic [31:0] f, logic nf);
        interval_t it;
        it = '{id, s, e, c, pr, f, nf};
        return it;
    endfunction

    function automatic alloc_t gold(logic [1:0] k, logic [4:0] rn, logic [16:0] s1,
                                    logic [16:0] s2, logic [31:0] gm, logic [31:0] xm,
                                    logic [16:0] sc);
        alloc_t a;
        a = '{k, rn, s1, s2, 1'b0, 16'd0, 17'd0, gm, xm, sc};
        return a;
    endfunction

    task automatic add_row(interval_t it, bit hg, alloc_t g);
        row_t r;
        r.item = it;
        r.has_golden = hg;
        r.golden = g;
        dir_rows.push_back(r);
    endtask

    // A random function: mostly well-formed sorted intervals with random classes and masks.
    task automatic run_function(int len);
        logic [15:0] pos;
        interval_t   it;
        int          k;
        pos = 16'($urandom_range(200));
        for (k = 0; k < len; k++)
        begin
            pos = pos + 16'($urandom_range(3));
            it.id = 16'($urandom);
            it.istart = pos;
            it.iend = pos + 16'($urandom_range(($urandom_range(3) == 0) ? 60000 : 40));
            if ($urandom_range(40) == 0)
                it.iend = pos - 16'($urandom_range(5));
            it.cls = ($urandom_range(9) < 8) ? 2'($urandom_range(1, 2)) :
                                               2'($urandom_range(3));
            it.paired = ($urandom_range(19) == 0);
            case ($urandom_range(3))
                0: it.forbid = $urandom;
                1: it.forbid = '1;
                default: it.forbid = $urandom & $urandom & $urandom;
            endcase
            it.newfn = (k == 0);
            // Now and then a fully random, unsorted beat.
            if ($urandom_range(30) == 0)
                it = interval_t'(84'({$urandom, $urandom, $urandom}));
            send_interval(it, 1'b0, '0);
        end
    endtask

    initial
    begin
        int i;
        int ph;
        alloc_t none;
        none = '0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        {reg_id, interval_start, interval_end, reg_class, is_paired, forbidden_mask,
         new_function} = '0;
        out_stall = 1'b0;
        fail_cnt = 0;
        in_idle_pct = 18;
        out_idle_pct = 62;
        live_cnt = 0;
        slot_next = '0;
        gpr_taken = '0;
        xmm_taken = '0;
        n_gpr = 6'd11;
        n_xmm = 6'd8;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table at reset counts: first register, paired, no class, class 3,
        // all forbidden, eviction, end before start, expiry, all-ones fields.
        add_row(mk(16'd0, 16'd0, 16'd10, CLS_GPR, 1'b0, 32'd0, 1'b1), 1'b1,
                gold(KIND_REG, 5'd0, 17'd0, 17'd0, 32'h1, 32'h0, 17'd0));
        add_row(mk(16'd1, 16'd0, 16'd10, CLS_XMM, 1'b0, 32'h1, 1'b0), 1'b1,
                gold(KIND_REG, 5'd1, 17'd0, 17'd0, 32'h1, 32'h2, 17'd0));
        add_row(mk(16'd2, 16'd1, 16'd5, CLS_GPR, 1'b1, 32'd0, 1'b0), 1'b1,
                gold(KIND_PAIR, 5'd0, 17'd0, 17'd1, 32'h1, 32'h2, 17'd2));
        add_row(mk(16'd3, 16'd1, 16'd5, CLS_NONE, 1'b0, 32'd0, 1'b0), 1'b1,
                gold(KIND_SPILL, 5'd0, 17'd2, 17'd0, 32'h1, 32'h2, 17'd3));
        add_row(mk(16'd4, 16'd1, 16'd5, CLS_RSVD, 1'b0, 32'd0, 1'b0), 1'b1,
                gold(KIND_SPILL, 5'd0, 17'd3, 17'd0, 32'h1, 32'h2, 17'd4));
        add_row(mk(16'd5, 16'd2, 16'd3, CLS_GPR, 1'b0, 32'hFFFF_FFFF, 1'b0), 1'b0, none);
        add_row(mk(16'd6, 16'd2, 16'd4, CLS_GPR, 1'b0, 32'hFFFF_FFFE, 1'b0), 1'b0, none);
        add_row(mk(16'd7, 16'd3, 16'd1, CLS_XMM, 1'b0, 32'd0, 1'b0), 1'b0, none);
        add_row(mk(16'd8, 16'd20, 16'd30, CLS_GPR, 1'b0, 32'd0, 1'b0), 1'b0, none);
        add_row(mk(16'hFFFF, 16'hFFFF, 16'hFFFF, CLS_RSVD, 1'b1, 32'hFFFF_FFFF, 1'b1),
                1'b1, gold(KIND_PAIR, 5'd0, 17'd0, 17'd1, 32'h0, 32'h0, 17'd2));
        add_row(mk(16'hFFFF, 16'hFFFF, 16'hFFFF, CLS_XMM, 1'b0, 32'd0, 1'b0), 1'b1,
                gold(KIND_REG, 5'd0, 17'd0, 17'd0, 32'h0, 32'h1, 17'd2));
        foreach (dir_rows[j])
            send_interval(dir_rows[j].item, dir_rows[j].has_golden, dir_rows[j].golden);
        wait_drained();

        // Register pressure and eviction with one general register and 63 vector registers.
        write_cfg(CFG_GPR_COUNT, 6'd1);
        write_cfg(CFG_XMM_COUNT, 6'd63);
        send_interval(mk(16'd10, 16'd0, 16'd900, CLS_GPR, 1'b0, 32'd0, 1'b1), 1'b0, none);
        send_interval(mk(16'd11, 16'd1, 16'd50, CLS_GPR, 1'b0, 32'd0, 1'b0), 1'b0, none);
        send_interval(mk(16'd12, 16'd2, 16'd5000, CLS_GPR, 1'b0, 32'd0, 1'b0), 1'b0, none);
        // Fill the active list to its depth and past it with vector intervals.
        for (i = 0; i < ACTIVE_DEPTH + 2; i++)
            send_interval(mk(i[15:0] + 16'd100, 16'd3, 16'd60000 - i[15:0], CLS_XMM, 1'b0,
                             32'd0, 1'b0), 1'b0, none);
        wait_drained();
        write_cfg(CFG_GPR_COUNT, 6'd0);
        write_cfg(CFG_XMM_COUNT, 6'd32);
        send_interval(mk(16'd13, 16'd0, 16'd9, CLS_GPR, 1'b0, 32'd0, 1'b1), 1'b0, none);
        wait_drained();

        // Random part in three idling phases with the class counts varied between them.
        for (ph = 0; ph < 3; ph++)
        begin
            in_idle_pct = (ph == 0) ? 18 : (ph == 1) ? 62 : 0;
            out_idle_pct = (ph == 0) ? 62 : (ph == 1) ? 18 : 0;
            for (i = 0; i < 7; i++)
            begin
                run_function($urandom_range(20, 70));
                if (i == 3)
                    wait_drained();
            end
            wait_drained();
            write_cfg(CFG_GPR_COUNT, (ph == 2) ? 6'd11 : 6'($urandom_range(1, 40)));
            write_cfg(CFG_XMM_COUNT, (ph == 0) ? 6'd2 : 6'($urandom_range(0, 63)));
        end
        // A run of paired spills inside one function, across all classes.
        send_interval(mk(16'd0, 16'd0, 16'd0, CLS_NONE, 1'b1, 32'd0, 1'b1), 1'b0, none);
        for (i = 0; i < 40; i++)
            send_interval(mk(i[15:0], 16'd0, 16'd0, 2'($urandom_range(3)), 1'b1, $urandom,
                             1'b0), 1'b0, none);
        wait_drained();

        if (fail_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
`default_nettype wire
